// File: src/sba_pkg.sv
// Shared constants, codes and a helper function for the segregated block allocator.
package sba_pkg;

    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 16;
    localparam int BYTES_W  = 13;
    localparam int STATUS_W = 2;
    localparam int OP_W     = 2;
    localparam int PCOUNT_W = 5;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_NUM_PAGES       = 16;
    localparam int DEF_PAGE_BYTES      = 4096;
    localparam int DEF_NUM_CLASSES     = 9;
    localparam int DEF_MAX_BLOCK_BYTES = 2048;

    localparam int MIN_BLOCK = 8;
    localparam int MIN_SHIFT = 3;
    localparam int MAX_ROUND = 13;
    localparam int ROUND_W   = 4;

    localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = PCOUNT_W'(16);

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT   = 1'b1;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
    localparam logic [OP_W-1:0] OP_INIT  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_RES   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 2'd3;

    // Class index of the smallest power-of-two block (at least 8 bytes) that holds v.
    function automatic logic [ROUND_W-1:0] round_class(input logic [31:0] v);
        int cnt;
        cnt = 0;
        for (int j = 0; j <= MAX_ROUND; j++)
        begin
            if ((32'(MIN_BLOCK) << j) < v)
            begin
                cnt = cnt + 1;
            end
        end
        return ROUND_W'(cnt);
    endfunction

endpackage

// File: src/sba_req_if.sv
// Request channel of the allocator: valid/ready handshake with op, size and address.
interface sba_req_if;
    import sba_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [SIZE_W-1:0]   req_size;
    logic [ADDR_W-1:0]   block_address;

    modport source (output valid, output op, output req_size, output block_address,
                    input ready);
    modport sink   (input valid, input op, input req_size, input block_address,
                    output ready);
endinterface

// File: src/sba_resp_if.sv
// Response channel of the allocator: valid/ready handshake with address, size and status.
interface sba_resp_if;
    import sba_pkg::*;

    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   result_address;
    logic [BYTES_W-1:0]  class_bytes;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output result_address, output class_bytes,
                    output status, input ready);
    modport sink   (input valid, input result_address, input class_bytes,
                    input status, output ready);
endinterface

// File: src/segregated_block_allocator.sv
// Segregated power-of-two block allocator: one request in, one response out.
//
// The allocator manages NUM_PAGES pages of PAGE_BYTES bytes from region_start and keeps a
// doubly linked free list per power-of-two size class (8 bytes up). The links live in two
// block RAMs (next and prev, one entry per 8-byte slot) with one write port each, and a small
// sequencer walks them one link update per cycle; that write port sets the cost. Requests are
// taken one at a time and the request channel stays low until the response is registered.
// An alloc that splits a fresh page links every block of it but the first into its class
// list, and a free that empties a page unlinks every block of it before the page returns to
// the free-page list. The link RAMs need no clearing pass: every slot at a block boundary is
// written when its page is split, before any free can look at it. Write the configuration
// registers only while idle, and issue init before the first alloc.
module segregated_block_allocator #(
    parameter int NUM_PAGES       = sba_pkg::DEF_NUM_PAGES,
    parameter int PAGE_BYTES      = sba_pkg::DEF_PAGE_BYTES,
    parameter int NUM_CLASSES     = sba_pkg::DEF_NUM_CLASSES,
    parameter int MAX_BLOCK_BYTES = sba_pkg::DEF_MAX_BLOCK_BYTES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sba_pkg::ADDR_W-1:0]     cfg_data,
    sba_req_if.sink                        req,
    sba_resp_if.source                     resp
);
    import sba_pkg::*;

    // Geometry derived from the parameters.
    localparam int SPP      = PAGE_BYTES / MIN_BLOCK;       // slots per page
    localparam int SPP_LOG  = $clog2(SPP);
    localparam int PAGE_LOG = $clog2(PAGE_BYTES);
    localparam int SLOTS    = NUM_PAGES * SPP;
    localparam int AW       = $clog2(SLOTS);                 // slot index
    localparam int SW       = $clog2(SLOTS + 2);             // link value (slot, null, detached)
    localparam int PW       = $clog2(NUM_PAGES + 1);         // page link (page or none)
    localparam int PIW      = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CW       = $clog2(NUM_CLASSES);
    localparam int CSW      = $clog2(PAGE_BYTES + 1);        // block size in bytes
    localparam int FBW      = $clog2(SPP + 1);               // free block count

    localparam logic [SW-1:0] NIL     = SW'(SLOTS);
    localparam logic [SW-1:0] DET     = SW'(SLOTS + 1);
    localparam logic [PW-1:0] NO_PAGE = PW'(NUM_PAGES);

    // Sequencer states.
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECODE    = 4'd1;
    localparam logic [3:0] S_DISPATCH  = 4'd2;
    localparam logic [3:0] S_UL_RD     = 4'd3;
    localparam logic [3:0] S_UL_LINK   = 4'd4;
    localparam logic [3:0] S_UL_DET    = 4'd5;
    localparam logic [3:0] S_TAKE_END  = 4'd6;
    localparam logic [3:0] S_SPLIT_A   = 4'd7;
    localparam logic [3:0] S_SPLIT_B   = 4'd8;
    localparam logic [3:0] S_SPLIT_END = 4'd9;
    localparam logic [3:0] S_FREE_RD   = 4'd10;
    localparam logic [3:0] S_FREE_CHK  = 4'd11;
    localparam logic [3:0] S_FREE_PUSH = 4'd12;
    localparam logic [3:0] S_FREE_NEXT = 4'd13;
    localparam logic [3:0] S_FREE_END  = 4'd14;
    localparam logic [3:0] S_DONE      = 4'd15;

    // Configuration.
    logic [ADDR_W-1:0]   region_start_reg;
    logic [PCOUNT_W-1:0] page_count_reg;

    // Page and class bookkeeping.
    logic [CSW-1:0] csize_reg [NUM_PAGES];
    logic [FBW-1:0] fb_reg    [NUM_PAGES];
    logic [PW-1:0]  link_reg  [NUM_PAGES];
    logic [PW-1:0]  pg_head_reg;
    logic [PW-1:0]  pg_tail_reg;
    logic [SW-1:0]  cls_head_reg [NUM_CLASSES];
    logic [SW-1:0]  cls_tail_reg [NUM_CLASSES];

    // Sequencer and working registers.
    logic [3:0]          state_reg;
    logic [3:0]          ret_reg;
    logic [OP_W-1:0]     op_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W-1:0]   off_reg;
    logic [ROUND_W-1:0]  kr_reg;
    logic [CW-1:0]       cls_reg;
    logic [PIW-1:0]      page_reg;
    logic [AW-1:0]       base_reg;
    logic [AW-1:0]       slot_reg;
    logic [AW-1:0]       us_reg;
    logic [SW-1:0]       h_reg;
    logic [FBW-1:0]      i_reg;
    logic [FBW-1:0]      cnt_reg;
    logic [ADDR_W-1:0]   res_addr_reg;
    logic [BYTES_W-1:0]  res_bytes_reg;
    logic [STATUS_W-1:0] res_st_reg;

    // Response register.
    logic                out_valid_reg;
    logic [ADDR_W-1:0]   out_addr_reg;
    logic [BYTES_W-1:0]  out_bytes_reg;
    logic [STATUS_W-1:0] out_st_reg;

    // Link RAM ports.
    logic          nx_we;
    logic [AW-1:0] nx_waddr;
    logic [SW-1:0] nx_wdata;
    logic [SW-1:0] nx_rdata;
    logic          pv_we;
    logic [AW-1:0] pv_waddr;
    logic [SW-1:0] pv_wdata;
    logic [AW-1:0] pv_raddr;
    logic [SW-1:0] pv_rdata;

    sba_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_next_ram (
        .clk   (clk),
        .we    (nx_we),
        .waddr (nx_waddr),
        .wdata (nx_wdata),
        .raddr (us_reg),
        .rdata (nx_rdata)
    );

    sba_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_prev_ram (
        .clk   (clk),
        .we    (pv_we),
        .waddr (pv_waddr),
        .wdata (pv_wdata),
        .raddr (pv_raddr),
        .rdata (pv_rdata)
    );

    // Decoded views of the working registers.
    logic [31:0]       act_pages;
    logic [31:0]       pg_num;
    logic              pg_in_range;
    logic [PIW-1:0]    pg_idx;
    logic [CSW-1:0]    pg_csize;
    logic [PAGE_LOG-1:0] within_masked;
    logic [AW-1:0]     pg_base;
    logic [AW-1:0]     free_slot;
    logic [31:0]       alloc_bytes;
    logic              size_bad;
    logic              borrow_found;
    logic [CW-1:0]     borrow_cls;
    logic [ROUND_W-1:0] free_round;
    logic [AW-1:0]     split_slot;
    logic [SW-1:0]     cur_tail;
    logic [SW-1:0]     cur_head;
    logic [PIW-1:0]    us_page;
    logic              ul_pv;
    logic              ul_nv;

    always_comb
    begin
        act_pages = (32'(page_count_reg) > 32'(NUM_PAGES)) ? 32'(NUM_PAGES)
                                                          : 32'(page_count_reg);
        pg_num        = off_reg >> PAGE_LOG;
        pg_in_range   = pg_num < act_pages;
        pg_idx        = pg_num[PIW-1:0];
        pg_csize      = csize_reg[pg_idx];
        // Round a misaligned address down to its block boundary.
        within_masked = off_reg[PAGE_LOG-1:0] & ~(PAGE_LOG'(pg_csize - CSW'(1)));
        pg_base       = AW'(pg_idx) << SPP_LOG;
        free_slot     = pg_base | AW'(within_masked >> MIN_SHIFT);
        free_round    = round_class(32'(pg_csize));

        alloc_bytes = 32'(MIN_BLOCK) << kr_reg;
        size_bad    = (size_reg == '0) || (32'(size_reg) > 32'(MAX_BLOCK_BYTES))
                   || (32'(kr_reg) >= 32'(NUM_CLASSES)) || (alloc_bytes > 32'(PAGE_BYTES));

        // First larger class with a free block.
        borrow_found = 1'b0;
        borrow_cls   = '0;
        for (int j = NUM_CLASSES - 1; j >= 0; j--)
        begin
            if ((32'(j) > 32'(kr_reg)) && (cls_head_reg[j] < NIL))
            begin
                borrow_found = 1'b1;
                borrow_cls   = CW'(j);
            end
        end

        split_slot = base_reg + (AW'(i_reg) << cls_reg);
        cur_tail   = cls_tail_reg[cls_reg];
        cur_head   = cls_head_reg[cls_reg];
        us_page    = PIW'(us_reg >> SPP_LOG);
        ul_pv      = pv_rdata < NIL;
        ul_nv      = nx_rdata < NIL;
    end

    // Link RAM control: one write per RAM per cycle.
    always_comb
    begin
        nx_we    = 1'b0;
        nx_waddr = us_reg;
        nx_wdata = DET;
        pv_we    = 1'b0;
        pv_waddr = us_reg;
        pv_wdata = DET;
        pv_raddr = (state_reg == S_FREE_RD) ? slot_reg : us_reg;
        case (state_reg)
            S_UL_LINK:
            begin
                nx_we    = ul_pv;
                nx_waddr = pv_rdata[AW-1:0];
                nx_wdata = ul_nv ? nx_rdata : NIL;
                pv_we    = ul_nv;
                pv_waddr = nx_rdata[AW-1:0];
                pv_wdata = ul_pv ? pv_rdata : NIL;
            end
            S_UL_DET:
            begin
                nx_we = 1'b1;
                pv_we = 1'b1;
            end
            S_SPLIT_A:
            begin
                nx_we    = cur_tail < NIL;
                nx_waddr = cur_tail[AW-1:0];
                nx_wdata = SW'(split_slot);
                pv_we    = 1'b1;
                pv_waddr = split_slot;
                pv_wdata = (cur_tail < NIL) ? cur_tail : NIL;
            end
            S_SPLIT_B:
            begin
                nx_we    = 1'b1;
                nx_wdata = NIL;
            end
            S_SPLIT_END:
            begin
                nx_we    = 1'b1;
                nx_waddr = base_reg;
                pv_we    = 1'b1;
                pv_waddr = base_reg;
            end
            S_FREE_CHK:
            begin
                nx_we    = pv_rdata == DET;
                nx_waddr = slot_reg;
                nx_wdata = (cur_head < NIL) ? cur_head : NIL;
                pv_we    = pv_rdata == DET;
                pv_waddr = slot_reg;
                pv_wdata = NIL;
            end
            S_FREE_PUSH:
            begin
                pv_we    = h_reg < NIL;
                pv_waddr = h_reg[AW-1:0];
                pv_wdata = SW'(slot_reg);
            end
            default:
            begin
                nx_we = 1'b0;
            end
        endcase
    end

    assign req.ready           = state_reg == S_IDLE;
    assign resp.valid          = out_valid_reg;
    assign resp.result_address = out_addr_reg;
    assign resp.class_bytes    = out_bytes_reg;
    assign resp.status         = out_st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_start_reg <= '0;
            page_count_reg   <= PCOUNT_RESET;
            for (int i = 0; i < NUM_PAGES; i++)
            begin
                csize_reg[i] <= '0;
                fb_reg[i]    <= '0;
                link_reg[i]  <= NO_PAGE;
            end
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                cls_head_reg[c] <= NIL;
                cls_tail_reg[c] <= NIL;
            end
            pg_head_reg   <= NO_PAGE;
            pg_tail_reg   <= NO_PAGE;
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_REGION_START: region_start_reg <= cfg_data;
                    CFG_PAGE_COUNT:   page_count_reg   <= cfg_data[PCOUNT_W-1:0];
                    default:          region_start_reg <= region_start_reg;
                endcase
            end

            // Drop the response once taken, unless a new one replaces it this cycle.
            if (out_valid_reg && resp.ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg    <= req.op;
                        size_reg  <= req.req_size;
                        addr_reg  <= req.block_address;
                        state_reg <= S_DECODE;
                    end
                end

                S_DECODE:
                begin
                    off_reg       <= addr_reg - region_start_reg;
                    kr_reg        <= round_class(32'(size_reg));
                    res_addr_reg  <= '0;
                    res_bytes_reg <= '0;
                    res_st_reg    <= ST_OK;
                    state_reg     <= S_DISPATCH;
                end

                S_DISPATCH:
                begin
                    case (op_reg)
                        OP_INIT:
                        begin
                            // Empty every class and chain all active pages in order.
                            for (int c = 0; c < NUM_CLASSES; c++)
                            begin
                                cls_head_reg[c] <= NIL;
                                cls_tail_reg[c] <= NIL;
                            end
                            for (int i = 0; i < NUM_PAGES; i++)
                            begin
                                csize_reg[i] <= '0;
                                fb_reg[i]    <= '0;
                                link_reg[i]  <= (32'(i + 1) < act_pages) ? PW'(i + 1) : NO_PAGE;
                            end
                            pg_head_reg <= (act_pages != '0) ? PW'(0) : NO_PAGE;
                            pg_tail_reg <= (act_pages != '0) ? PW'(act_pages - 32'd1) : NO_PAGE;
                            state_reg   <= S_DONE;
                        end

                        OP_QUERY:
                        begin
                            if (!pg_in_range)
                            begin
                                res_st_reg <= ST_BAD_ADDR;
                            end
                            else
                            begin
                                res_bytes_reg <= BYTES_W'(pg_csize);
                            end
                            state_reg <= S_DONE;
                        end

                        OP_ALLOC:
                        begin
                            if (size_bad)
                            begin
                                res_st_reg <= ST_BAD_SIZE;
                                state_reg  <= S_DONE;
                            end
                            else if (cls_head_reg[CW'(kr_reg)] < NIL)
                            begin
                                cls_reg   <= CW'(kr_reg);
                                us_reg    <= cls_head_reg[CW'(kr_reg)][AW-1:0];
                                ret_reg   <= S_TAKE_END;
                                state_reg <= S_UL_RD;
                            end
                            else if (pg_head_reg < NO_PAGE)
                            begin
                                // Take the first free page and carve it up.
                                if (link_reg[pg_head_reg[PIW-1:0]] >= NO_PAGE)
                                begin
                                    pg_head_reg <= NO_PAGE;
                                    pg_tail_reg <= NO_PAGE;
                                end
                                else
                                begin
                                    pg_head_reg <= link_reg[pg_head_reg[PIW-1:0]];
                                end
                                link_reg[pg_head_reg[PIW-1:0]]  <= NO_PAGE;
                                csize_reg[pg_head_reg[PIW-1:0]] <= CSW'(alloc_bytes);
                                page_reg  <= pg_head_reg[PIW-1:0];
                                base_reg  <= AW'(pg_head_reg[PIW-1:0]) << SPP_LOG;
                                cls_reg   <= CW'(kr_reg);
                                i_reg     <= FBW'(1);
                                cnt_reg   <= FBW'(32'(SPP) >> kr_reg);
                                state_reg <= ((32'(SPP) >> kr_reg) > 32'd1) ? S_SPLIT_A
                                                                              : S_SPLIT_END;
                            end
                            else if (borrow_found)
                            begin
                                cls_reg   <= borrow_cls;
                                us_reg    <= cls_head_reg[borrow_cls][AW-1:0];
                                ret_reg   <= S_TAKE_END;
                                state_reg <= S_UL_RD;
                            end
                            else
                            begin
                                res_st_reg <= ST_NO_RES;
                                state_reg  <= S_DONE;
                            end
                        end

                        default:
                        begin
                            // Free: check the page, then look at the block's prev link.
                            if (!pg_in_range || (pg_csize == '0)
                                || (32'(free_round) >= 32'(NUM_CLASSES)))
                            begin
                                res_st_reg <= ST_BAD_ADDR;
                                state_reg  <= S_DONE;
                            end
                            else
                            begin
                                page_reg  <= pg_idx;
                                base_reg  <= pg_base;
                                slot_reg  <= free_slot;
                                cls_reg   <= CW'(free_round);
                                cnt_reg   <= FBW'(32'(SPP) >> free_round);
                                state_reg <= S_FREE_RD;
                            end
                        end
                    endcase
                end

                S_UL_RD:
                begin
                    state_reg <= S_UL_LINK;
                end

                S_UL_LINK:
                begin
                    // Patch neighbors; a missing neighbor moves the list end instead.
                    if (!ul_pv)
                    begin
                        cls_head_reg[cls_reg] <= ul_nv ? nx_rdata : NIL;
                    end
                    if (!ul_nv)
                    begin
                        cls_tail_reg[cls_reg] <= ul_pv ? pv_rdata : NIL;
                    end
                    state_reg <= S_UL_DET;
                end

                S_UL_DET:
                begin
                    state_reg <= ret_reg;
                end

                S_TAKE_END:
                begin
                    if (fb_reg[us_page] != '0)
                    begin
                        fb_reg[us_page] <= fb_reg[us_page] - FBW'(1);
                    end
                    res_addr_reg <= region_start_reg + (ADDR_W'(us_reg) << MIN_SHIFT);
                    state_reg    <= S_DONE;
                end

                S_SPLIT_A:
                begin
                    if (cur_tail >= NIL)
                    begin
                        cls_head_reg[cls_reg] <= SW'(split_slot);
                    end
                    us_reg    <= split_slot;
                    state_reg <= S_SPLIT_B;
                end

                S_SPLIT_B:
                begin
                    cls_tail_reg[cls_reg] <= SW'(us_reg);
                    i_reg                 <= i_reg + FBW'(1);
                    state_reg <= ((i_reg + FBW'(1)) == cnt_reg) ? S_SPLIT_END : S_SPLIT_A;
                end

                S_SPLIT_END:
                begin
                    fb_reg[page_reg] <= cnt_reg - FBW'(1);
                    res_addr_reg     <= region_start_reg + (ADDR_W'(base_reg) << MIN_SHIFT);
                    state_reg        <= S_DONE;
                end

                S_FREE_RD:
                begin
                    state_reg <= S_FREE_CHK;
                end

                S_FREE_CHK:
                begin
                    if (pv_rdata != DET)
                    begin
                        // Block already free.
                        res_st_reg <= ST_BAD_ADDR;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        h_reg                 <= cur_head;
                        cls_head_reg[cls_reg] <= SW'(slot_reg);
                        if (cur_head >= NIL)
                        begin
                            cls_tail_reg[cls_reg] <= SW'(slot_reg);
                        end
                        fb_reg[page_reg] <= fb_reg[page_reg] + FBW'(1);
                        state_reg        <= S_FREE_PUSH;
                    end
                end

                S_FREE_PUSH:
                begin
                    if (fb_reg[page_reg] >= cnt_reg)
                    begin
                        // Whole page free: unlink every block of it.
                        i_reg     <= '0;
                        us_reg    <= base_reg;
                        ret_reg   <= S_FREE_NEXT;
                        state_reg <= S_UL_RD;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end

                S_FREE_NEXT:
                begin
                    i_reg <= i_reg + FBW'(1);
                    if ((i_reg + FBW'(1)) == cnt_reg)
                    begin
                        state_reg <= S_FREE_END;
                    end
                    else
                    begin
                        us_reg    <= base_reg + (AW'(i_reg + FBW'(1)) << cls_reg);
                        state_reg <= S_UL_RD;
                    end
                end

                S_FREE_END:
                begin
                    csize_reg[page_reg] <= '0;
                    fb_reg[page_reg]    <= '0;
                    link_reg[page_reg]  <= NO_PAGE;
                    if (pg_tail_reg < NO_PAGE)
                    begin
                        link_reg[pg_tail_reg[PIW-1:0]] <= PW'(page_reg);
                    end
                    else
                    begin
                        pg_head_reg <= PW'(page_reg);
                    end
                    pg_tail_reg <= PW'(page_reg);
                    state_reg   <= S_DONE;
                end

                default:
                begin
                    // Hold the result until the response register is free.
                    if (!out_valid_reg || resp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_addr_reg  <= res_addr_reg;
                        out_bytes_reg <= res_bytes_reg;
                        out_st_reg    <= res_st_reg;
                        state_reg     <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

// File: src/sba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sba_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: test/segregated_block_allocator_tb.sv
// Self-checking testbench for the segregated block allocator.
`timescale 1ns / 100ps

module segregated_block_allocator_tb;
    import sba_pkg::*;

    localparam int NUM_PAGES    = DEF_NUM_PAGES;
    localparam int PAGE_BYTES   = DEF_PAGE_BYTES;
    localparam int NUM_CLASSES  = DEF_NUM_CLASSES;
    localparam int MAX_BYTES    = DEF_MAX_BLOCK_BYTES;
    localparam int PAGE_SLOTS   = PAGE_BYTES / MIN_BLOCK;
    localparam int SLOTS        = NUM_PAGES * PAGE_SLOTS;
    localparam int NIL          = SLOTS;
    localparam int DETACHED     = SLOTS + 1;
    localparam int NO_PAGE      = NUM_PAGES;
    localparam int PHASES       = 5;
    localparam int RANDOM_ITEMS = 320;

    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [BYTES_W-1:0]  bytes;
        logic [STATUS_W-1:0] status;
    } response_t;

    typedef struct {
        logic [31:0] addr;
        int unsigned bytes;
    } grant_t;

    // Tracks the allocator's lists and predicts one response per request.
    class alloc_scoreboard;
        logic [31:0] region_base;
        int unsigned page_limit;
        int unsigned pg_size[NUM_PAGES];
        int unsigned pg_free[NUM_PAGES];
        int unsigned pg_link[NUM_PAGES];
        int unsigned fp_head, fp_tail;
        int unsigned nxt[SLOTS];
        int unsigned prv[SLOTS];
        int unsigned c_head[NUM_CLASSES];
        int unsigned c_tail[NUM_CLASSES];
        response_t   awaited[$];
        grant_t      granted[$];
        int          errors;

        function new();
            region_base = '0;
            page_limit  = 16;
            errors      = 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                nxt[i] = 0;
                prv[i] = 0;
            end
            clear_lists();
        endfunction

        function void clear_lists();
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                c_head[i] = NIL;
                c_tail[i] = NIL;
            end
            for (int i = 0; i < NUM_PAGES; i++)
            begin
                pg_size[i] = 0;
                pg_free[i] = 0;
                pg_link[i] = NO_PAGE;
            end
            fp_head = NO_PAGE;
            fp_tail = NO_PAGE;
        endfunction

        function int unsigned active_pages();
            return (page_limit > NUM_PAGES) ? NUM_PAGES : page_limit;
        endfunction

        function void list_append(int unsigned c, int unsigned s);
            int unsigned t;
            t = c_tail[c];
            prv[s] = (t < SLOTS) ? t : NIL;
            nxt[s] = NIL;
            if (t < SLOTS) nxt[t] = s;
            else c_head[c] = s;
            c_tail[c] = s;
        endfunction

        function void list_push(int unsigned c, int unsigned s);
            int unsigned h;
            h = c_head[c];
            nxt[s] = (h < SLOTS) ? h : NIL;
            prv[s] = NIL;
            if (h < SLOTS) prv[h] = s;
            else c_tail[c] = s;
            c_head[c] = s;
        endfunction

        function void list_unlink(int unsigned c, int unsigned s);
            int unsigned p, n;
            p = prv[s];
            n = nxt[s];
            if (p < SLOTS) nxt[p] = (n < SLOTS) ? n : NIL;
            else c_head[c] = (n < SLOTS) ? n : NIL;
            if (n < SLOTS) prv[n] = (p < SLOTS) ? p : NIL;
            else c_tail[c] = (p < SLOTS) ? p : NIL;
            prv[s] = DETACHED;
            nxt[s] = DETACHED;
        endfunction

        function int unsigned take_head(int unsigned c);
            int unsigned s;
            s = c_head[c];
            list_unlink(c, s);
            if (pg_free[s / PAGE_SLOTS] > 0) pg_free[s / PAGE_SLOTS]--;
            return s;
        endfunction

        function void page_append(int unsigned p);
            pg_link[p] = NO_PAGE;
            if (fp_tail < NO_PAGE) pg_link[fp_tail] = p;
            else fp_head = p;
            fp_tail = p;
        endfunction

        function logic [STATUS_W-1:0] predict_alloc(int unsigned size, output logic [31:0] addr);
            int unsigned bytes, k, s, p, n, step, base;
            bit found;
            bytes = MIN_BLOCK;
            k     = 0;
            found = 0;
            s     = 0;
            addr  = '0;
            if (size == 0 || size > MAX_BYTES) return ST_BAD_SIZE;
            while (bytes < size)
            begin
                bytes = bytes << 1;
                k++;
            end
            if (k >= NUM_CLASSES || bytes > PAGE_BYTES) return ST_BAD_SIZE;
            if (c_head[k] < SLOTS)
            begin
                s = take_head(k);
            end
            else if (fp_head < NO_PAGE)
            begin
                // split the first free page, grant its first block
                p    = fp_head;
                n    = PAGE_BYTES / bytes;
                step = bytes >> MIN_SHIFT;
                base = p * PAGE_SLOTS;
                fp_head = pg_link[p];
                if (fp_head >= NO_PAGE)
                begin
                    fp_head = NO_PAGE;
                    fp_tail = NO_PAGE;
                end
                pg_link[p] = NO_PAGE;
                pg_size[p] = bytes;
                for (int unsigned i = 1; i < n; i++) list_append(k, base + i * step);
                prv[base] = DETACHED;
                nxt[base] = DETACHED;
                pg_free[p] = n - 1;
                s = base;
            end
            else
            begin
                // borrow from the first larger class that has a block
                for (int unsigned j = k + 1; j < NUM_CLASSES && !found; j++)
                begin
                    if (c_head[j] < SLOTS)
                    begin
                        s = take_head(j);
                        found = 1;
                    end
                end
                if (!found) return ST_NO_RES;
            end
            addr = region_base + 32'(s << MIN_SHIFT);
            granted.push_back('{addr: addr, bytes: pg_size[s / PAGE_SLOTS]});
            return ST_OK;
        endfunction

        function logic [STATUS_W-1:0] predict_free(logic [31:0] address);
            logic [31:0] off;
            int unsigned p, size, in_page, s, k, c, n, step, base;
            off = address - region_base;
            p   = off / PAGE_BYTES;
            k   = 0;
            c   = MIN_BLOCK;
            if (p >= active_pages()) return ST_BAD_ADDR;
            size = pg_size[p];
            if (size == 0) return ST_BAD_ADDR;
            in_page = off % PAGE_BYTES;
            in_page = in_page - (in_page % size);
            base    = p * PAGE_SLOTS;
            s       = base + (in_page >> MIN_SHIFT);
            if (prv[s] != DETACHED) return ST_BAD_ADDR;
            while (c < size)
            begin
                c = c << 1;
                k++;
            end
            if (k >= NUM_CLASSES) return ST_BAD_ADDR;
            list_push(k, s);
            pg_free[p]++;
            foreach (granted[i])
            begin
                if (granted[i].addr == region_base + 32'(s << MIN_SHIFT))
                begin
                    granted.delete(i);
                    break;
                end
            end
            n = PAGE_BYTES / size;
            if (pg_free[p] >= n)
            begin
                // whole page free again: drop its blocks, hand the page back
                step = size >> MIN_SHIFT;
                for (int unsigned i = 0; i < n; i++) list_unlink(k, base + i * step);
                pg_size[p] = 0;
                pg_free[p] = 0;
                page_append(p);
            end
            return ST_OK;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [SIZE_W-1:0] size,
                                   logic [ADDR_W-1:0] address);
            response_t r;
            int unsigned p;
            r = '0;
            case (op)
                OP_ALLOC: r.status = predict_alloc(size, r.addr);
                OP_FREE:  r.status = predict_free(address);
                OP_QUERY:
                begin
                    p = (address - region_base) / PAGE_BYTES;
                    if (p >= active_pages()) r.status = ST_BAD_ADDR;
                    else r.bytes = BYTES_W'(pg_size[p]);
                end
                default:
                begin
                    clear_lists();
                    for (int unsigned i = 0; i < active_pages(); i++) page_append(i);
                    granted.delete();
                end
            endcase
            awaited.push_back(r);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
            errors++;
        endtask

        task check_response(response_t got);
            response_t want;
            if (awaited.size() == 0)
            begin
                report_mismatch("unexpected response", got.addr, 0);
                return;
            end
            want = awaited.pop_front();
            if (got.addr !== want.addr) report_mismatch("result_address", got.addr, want.addr);
            if (got.bytes !== want.bytes) report_mismatch("class_bytes", got.bytes, want.bytes);
            if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0] cfg_data;

    sba_req_if  req ();
    sba_resp_if resp ();

    segregated_block_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req.sink),
        .resp      (resp.source)
    );

    alloc_scoreboard sb;
    bit idle_on;          // when clear, both sides run without gaps
    int hold_cycles;      // long receiver hold-off requested by the sender

    always #5 clk = ~clk;

    // Watchdog: a correct run finishes far earlier than this.
    initial
    begin
        #200_000_000;
        $display("segregated_block_allocator_tb: errors");
        $finish;
    end

    // Pick a gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Response side: check each accepted response, then decide ready for the next edge.
    initial
    begin
        int stall;
        response_t got;
        stall = 0;
        resp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (resp.valid && resp.ready)
            begin
                got.addr   = resp.result_address;
                got.bytes  = resp.class_bytes;
                got.status = resp.status;
                sb.check_response(got);
            end
            if (hold_cycles > 0)
            begin
                // long hold-off: the allocator must stall its request side
                stall = hold_cycles;
                hold_cycles = 0;
            end
            else if (stall == 0)
            begin
                stall = pick_gap();
            end
            if (stall > 0)
            begin
                resp.ready <= 1'b0;
                stall--;
            end
            else
            begin
                resp.ready <= 1'b1;
            end
        end
    end

    // Offer one request and hold it until accepted; valid stays high into a back-to-back
    // request, so it is only lowered when a gap follows.
    task send_request(logic [OP_W-1:0] op, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] address);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid         <= 1'b1;
        req.op            <= op;
        req.req_size      <= size;
        req.block_address <= address;
        do
            @(posedge clk);
        while (!req.ready);
        sb.note_request(op, size, address);
    endtask

    task drain_responses();
        req.valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write one register, then deassert cfg_we and wait before the next write.
    task write_register(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_REGION_START) sb.region_base = value;
        else sb.page_limit = value[PCOUNT_W-1:0];
        @(posedge clk);
    endtask

    // Random request: mostly allocs and frees of live blocks, so pages get split and
    // handed back, plus queries, stray addresses and the odd init.
    task send_random();
        int r, idx;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] address;
        grant_t g;
        r       = $urandom_range(0, 99);
        size    = SIZE_W'($urandom());
        address = $urandom();
        if (r < 46)
        begin
            if ($urandom_range(0, 19) != 0)
                size = SIZE_W'($urandom_range(1, 1 << $urandom_range(0, 11)));
            send_request(OP_ALLOC, size, address);
        end
        else if (r < 86)
        begin
            if (sb.granted.size() != 0 && $urandom_range(0, 9) != 0)
            begin
                idx = $urandom_range(0, sb.granted.size() - 1);
                g = sb.granted[idx];
                address = g.addr;
                if ($urandom_range(0, 3) == 0) address = address + $urandom_range(0, g.bytes - 1);
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                address = sb.region_base + $urandom_range(0, NUM_PAGES * PAGE_BYTES + 8191);
            end
            send_request(OP_FREE, size, address);
        end
        else if (r < 98)
        begin
            if ($urandom_range(0, 2) != 0)
                address = sb.region_base + $urandom_range(0, NUM_PAGES * PAGE_BYTES + 8191);
            send_request(OP_QUERY, size, address);
        end
        else
        begin
            send_request(OP_INIT, size, address);
        end
    endtask

    initial
    begin
        logic [ADDR_W-1:0] bases [PHASES];
        int unsigned counts [PHASES];
        bit ok;
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_REGION_START;
        cfg_data = '0;
        req.valid = 1'b0;
        req.op = OP_INIT;
        req.req_size = '0;
        req.block_address = '0;
        idle_on = 1'b1;
        hold_cycles = 0;
        bases  = '{32'h0, 32'hFFFF_F800, $urandom(), 32'hFFFF_FFFF, $urandom()};
        counts = '{16, 2, 0, 31, 1};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, still at reset settings: alloc before init, size limits,
        // misaligned and double frees, a page handed back, addresses out of range.
        send_request(OP_ALLOC, 8, 0);
        send_request(OP_QUERY, 0, 0);
        send_request(OP_INIT, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(OP_ALLOC, 0, 0);
        send_request(OP_ALLOC, SIZE_W'(MAX_BYTES + 1), 0);
        send_request(OP_ALLOC, 16'hFFFF, 0);
        send_request(OP_ALLOC, 1, 0);
        send_request(OP_ALLOC, SIZE_W'(MAX_BYTES), 0);
        send_request(OP_ALLOC, SIZE_W'(MAX_BYTES), 0);
        send_request(OP_QUERY, 0, 4100);
        send_request(OP_FREE, 0, 4096 + 5);
        send_request(OP_FREE, 0, 4096);
        send_request(OP_FREE, 0, 6144);
        send_request(OP_QUERY, 0, 4096);
        send_request(OP_FREE, 0, 8192 + 16);
        send_request(OP_FREE, 0, ADDR_W'(NUM_PAGES * PAGE_BYTES));
        send_request(OP_QUERY, 0, 32'hFFFF_FFFF);
        send_request(OP_ALLOC, 9, 0);
        send_request(OP_ALLOC, 1024, 0);
        send_request(OP_ALLOC, 512, 0);
        drain_responses();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_register(CFG_REGION_START, bases[ph]);
            write_register(CFG_PAGE_COUNT, ADDR_W'(counts[ph]));
            idle_on = (ph != 2);
            send_request(OP_INIT, 0, 0);
            if (counts[ph] == 1)
            begin
                // one page only: a 2048-byte split leaves a block a small alloc borrows
                send_request(OP_ALLOC, SIZE_W'(MAX_BYTES), 0);
                send_request(OP_ALLOC, 8, 0);
                send_request(OP_ALLOC, 8, 0);
            end
            for (int i = 0; i < RANDOM_ITEMS; i++)
            begin
                if (ph == 1 && i == 40) hold_cycles = 400;
                if (i == RANDOM_ITEMS / 2) drain_responses();
                send_random();
            end
            drain_responses();
        end

        ok = (sb.errors == 0) && (sb.awaited.size() == 0);
        if (ok)
            $display("segregated_block_allocator_tb: clean");
        else
            $display("segregated_block_allocator_tb: errors");
        $finish;
    end

endmodule
